/* sv/tat_pkg.sv */
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants of the tcp ack timeout flow tracker: flow entry
// layout, tcp flag masks, event codes, register map and state encoding.
// ----------------------------------------------------------------------------
package tat_pkg;

    // default table geometry
    localparam int DEF_BUCKETS = 16;
    localparam int DEF_WAYS    = 4;

    // tcp flag byte masks
    localparam logic [7:0] FL_FIN    = 8'h01;
    localparam logic [7:0] FL_SYN    = 8'h02;
    localparam logic [7:0] FL_RST    = 8'h04;
    localparam logic [7:0] FL_ACK    = 8'h10;
    localparam logic [7:0] FL_SYNACK = 8'h12;

    // duplicate acks always sent on a timeout
    localparam logic [6:0] BASE_DUPS = 7'd3;

    // register map, selected by paddr[2]
    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_DUP_EXTRA = 1'b1;
    localparam int   PADDR_W       = 3;

    // event codes on event_res
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CREATED  = 3'd1,
        EV_ESTAB    = 3'd2,
        EV_FINISHED = 3'd3,
        EV_FULL     = 3'd4
    } event_t;

    // one way of a bucket row
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic        established;
        logic [31:0] adapter;
        logic [31:0] sent_seq;
        logic [31:0] rcv_ack;
        logic [31:0] rcv_time;
        logic        rcv_seen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // control sequencer
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QB,
        ST_IDX,
        ST_MATCH,
        ST_APPLY
    } state_t;

endpackage

/* sv/tat_ram.sv */
// ----------------------------------------------------------------------------
// tat_ram
// Generic single write port, single read port ram with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module tat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tcp_ack_timeout_flow_tracker.sv */
// ----------------------------------------------------------------------------
// tcp_ack_timeout_flow_tracker
// Flow table for tcp ack timeout detection, one bucket row per ram word.
// ----------------------------------------------------------------------------
// order: idle captures the word, then qb, idx and match; apply registers the
//   result once the output is free; a new word is taken only in idle, after
//   the bucket reduction and the read, match and write back of one bucket row
//   in the single ram. reset: rst_n clears control state, then a clearing pass
//   writes every row with in_ready low; register writes are taken meanwhile
module tcp_ack_timeout_flow_tracker #(
    parameter int BUCKETS = tat_pkg::DEF_BUCKETS,
    parameter int WAYS    = tat_pkg::DEF_WAYS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tat_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        outbound,
    input  logic                        tcp_valid,
    input  logic [7:0]                  tcp_flags,
    input  logic [31:0]                 peer_ip,
    input  logic [15:0]                 peer_port,
    input  logic [15:0]                 local_port,
    input  logic [31:0]                 seq_num,
    input  logic [31:0]                 ack_num,
    input  logic [31:0]                 now_ticks,
    input  logic [31:0]                 adapter_id,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        flow_hit,
    output logic [5:0]                  flow_slot,
    output logic [2:0]                  event_res,
    output logic                        dup_ack_request,
    output logic [6:0]                  dup_ack_count,
    output logic [31:0]                 dup_adapter
);

    localparam int BKT_L  = $clog2(BUCKETS);
    localparam int BKT_W  = (BUCKETS > 1) ? BKT_L : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W  = WAYS * tat_pkg::ENTRY_W;
    localparam int RW     = BKT_L + 1;
    localparam int SH     = 32 + BKT_L;
    localparam int SLOT_W = (BKT_W + WAY_W + 1 > 6) ? (BKT_W + WAY_W + 1) : 6;
    // reciprocal of BUCKETS; the quotient estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((65'd1 << SH) / BUCKETS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] timeout_reg;
    logic [5:0]  dup_extra_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= '0;
            dup_extra_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == tat_pkg::REG_TIMEOUT)
            begin
                timeout_reg <= pwdata;
            end
            else
            begin
                dup_extra_reg <= pwdata[5:0];
            end
        end
    end

    // register readback
    always_comb
    begin
        if (paddr[2] == tat_pkg::REG_TIMEOUT)
        begin
            prdata = timeout_reg;
        end
        else
        begin
            prdata = {26'd0, dup_extra_reg};
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    tat_pkg::state_t state_reg, state_next;
    logic [BKT_W-1:0] clr_cnt_reg;
    logic             clr_last;
    logic             out_valid_reg;
    logic             out_free;
    logic             in_acc;

    assign clr_last = (clr_cnt_reg == BKT_W'(BUCKETS - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tat_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = tat_pkg::ST_IDLE;
                end
            end
            tat_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tat_pkg::ST_QB;
                end
            end
            tat_pkg::ST_QB:    state_next = tat_pkg::ST_IDX;
            tat_pkg::ST_IDX:   state_next = tat_pkg::ST_MATCH;
            tat_pkg::ST_MATCH: state_next = tat_pkg::ST_APPLY;
            tat_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = tat_pkg::ST_IDLE;
                end
            end
            default: state_next = tat_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tat_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tat_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + BKT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // input word capture and bucket reduction
    // ------------------------------------------------------------------
    logic        outbound_reg;
    logic        tcp_valid_reg;
    logic [7:0]  flags_reg;
    logic [31:0] ip_reg;
    logic [63:0] key_reg;
    logic [31:0] seq_reg;
    logic [31:0] ack_reg;
    logic [31:0] now_reg;
    logic [31:0] adapter_reg;
    logic [31:0] q_reg;
    logic [31:0] qb_reg;
    logic [BKT_W-1:0] bucket_reg;
    logic [64:0] prod;
    logic [RW-1:0] rem;
    logic [RW-1:0] rem_fix;

    assign prod = 65'(peer_ip) * 65'(RECIP);

    // remainder is below twice BUCKETS, one correction step
    always_comb
    begin
        rem     = ip_reg[RW-1:0] - qb_reg[RW-1:0];
        rem_fix = (rem >= RW'(BUCKETS)) ? (rem - RW'(BUCKETS)) : rem;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            outbound_reg  <= outbound;
            tcp_valid_reg <= tcp_valid;
            flags_reg     <= tcp_flags;
            ip_reg        <= peer_ip;
            key_reg       <= {peer_ip, peer_port, local_port};
            seq_reg       <= seq_num;
            ack_reg       <= ack_num;
            now_reg       <= now_ticks;
            adapter_reg   <= adapter_id;
            q_reg         <= 32'(prod >> SH);
        end
        if (state_reg == tat_pkg::ST_QB)
        begin
            qb_reg <= 32'(43'(q_reg) * 43'(BUCKETS));
        end
        if (state_reg == tat_pkg::ST_IDX)
        begin
            bucket_reg <= BKT_W'(rem_fix);
        end
    end

    // ------------------------------------------------------------------
    // bucket row memory
    // ------------------------------------------------------------------
    logic             ram_we;
    logic             ram_re;
    logic [BKT_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row_new;
    logic             apply_hit;

    tat_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (BKT_W'(rem_fix)),
        .rdata (ram_rdata)
    );

    // sequencer outputs
    always_comb
    begin
        in_ready  = (state_reg == tat_pkg::ST_IDLE);
        ram_re    = (state_reg == tat_pkg::ST_IDX);
        ram_we    = 1'b0;
        ram_waddr = bucket_reg;
        ram_wdata = row_new;
        if (state_reg == tat_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == tat_pkg::ST_APPLY)
        begin
            ram_we = out_free && apply_hit;
        end
    end

    // ------------------------------------------------------------------
    // way match
    // ------------------------------------------------------------------
    tat_pkg::entry_t  row_ways [WAYS];
    logic             match_any;
    logic [WAY_W-1:0] match_way;
    logic             free_any;
    logic [WAY_W-1:0] free_way;
    logic             found_reg;
    logic             free_ok_reg;
    logic [WAY_W-1:0] way_reg;
    tat_pkg::entry_t  ent_reg;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            row_ways[w] = ram_rdata[w*tat_pkg::ENTRY_W +: tat_pkg::ENTRY_W];
        end
    end

    // lowest matching way and lowest free way
    always_comb
    begin
        match_any = 1'b0;
        match_way = '0;
        free_any  = 1'b0;
        free_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_ways[w].valid && (row_ways[w].key == key_reg))
            begin
                match_any = 1'b1;
                match_way = WAY_W'(w);
            end
            if (!row_ways[w].valid)
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tat_pkg::ST_MATCH)
        begin
            found_reg   <= tcp_valid_reg && match_any;
            free_ok_reg <= free_any;
            way_reg     <= match_any ? match_way : free_way;
            ent_reg     <= row_ways[match_any ? match_way : free_way];
        end
    end

    // ------------------------------------------------------------------
    // entry update and result
    // ------------------------------------------------------------------
    tat_pkg::entry_t  ent;
    tat_pkg::event_t  ev;
    logic             dup;
    logic             done;
    logic [31:0]      gap;
    logic [31:0]      nxt;
    logic [SLOT_W-1:0] slot_full;

    always_comb
    begin
        ent       = ent_reg;
        ev        = tat_pkg::EV_NONE;
        apply_hit = found_reg;
        dup       = 1'b0;
        done      = 1'b0;
        gap       = '0;
        nxt       = '0;

        // syn+ack creates or refreshes the flow
        if (tcp_valid_reg && (flags_reg == tat_pkg::FL_SYNACK))
        begin
            if (found_reg)
            begin
                ent.established = 1'b0;
                ent.adapter     = '0;
                ent.rcv_time    = '0;
                ent.rcv_seen    = 1'b0;
                ev              = tat_pkg::EV_CREATED;
            end
            else if (free_ok_reg)
            begin
                ent       = '0;
                ent.valid = 1'b1;
                ent.key   = key_reg;
                apply_hit = 1'b1;
                ev        = tat_pkg::EV_CREATED;
            end
            else
            begin
                ev = tat_pkg::EV_FULL;
            end
        end

        if (apply_hit)
        begin
            // outbound: track seq, first pure ack establishes
            if (outbound_reg)
            begin
                ent.sent_seq = seq_reg;
                if (((flags_reg & tat_pkg::FL_ACK) != '0) &&
                    ((flags_reg & tat_pkg::FL_SYN) == '0) &&
                    !ent.rcv_seen && !ent.established)
                begin
                    ent.established = 1'b1;
                    ent.adapter     = adapter_reg;
                    ev              = tat_pkg::EV_ESTAB;
                    done            = 1'b1;
                end
            end
            if (!done)
            begin
                // inbound pure ack: timeout check
                if (!outbound_reg &&
                    ((flags_reg & (tat_pkg::FL_ACK | tat_pkg::FL_SYN)) == tat_pkg::FL_ACK))
                begin
                    gap = now_reg - ent.rcv_time;
                    nxt = ent.sent_seq + 32'd1;
                    dup = ent.rcv_seen && (gap > timeout_reg) && (nxt > ent.rcv_ack);
                    ent.rcv_ack  = ack_reg;
                    ent.rcv_time = now_reg;
                    ent.rcv_seen = 1'b1;
                end
                // fin or rst drops the flow
                if ((flags_reg & (tat_pkg::FL_FIN | tat_pkg::FL_RST)) != '0)
                begin
                    ent.valid = 1'b0;
                    ev        = tat_pkg::EV_FINISHED;
                end
            end
        end
    end

    // write back row with the touched way replaced
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == way_reg)
            begin
                row_new[w*tat_pkg::ENTRY_W +: tat_pkg::ENTRY_W] = ent;
            end
            else
            begin
                row_new[w*tat_pkg::ENTRY_W +: tat_pkg::ENTRY_W] = row_ways[w];
            end
        end
    end

    assign slot_full = SLOT_W'(bucket_reg) * SLOT_W'(WAYS) + SLOT_W'(way_reg);

    // ------------------------------------------------------------------
    // output word register
    // ------------------------------------------------------------------
    logic        flow_hit_reg;
    logic [5:0]  flow_slot_reg;
    logic [2:0]  event_res_reg;
    logic        dup_req_reg;
    logic [6:0]  dup_cnt_reg;
    logic [31:0] dup_adp_reg;
    logic        out_load;

    assign out_load = (state_reg == tat_pkg::ST_APPLY) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            flow_hit_reg  <= apply_hit;
            flow_slot_reg <= apply_hit ? slot_full[5:0] : 6'd0;
            event_res_reg <= ev;
            dup_req_reg   <= dup;
            dup_cnt_reg   <= dup ? (tat_pkg::BASE_DUPS + 7'(dup_extra_reg)) : 7'd0;
            dup_adp_reg   <= dup ? ent_reg.adapter : 32'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign flow_hit        = flow_hit_reg;
    assign flow_slot       = flow_slot_reg;
    assign event_res       = event_res_reg;
    assign dup_ack_request = dup_req_reg;
    assign dup_ack_count   = dup_cnt_reg;
    assign dup_adapter     = dup_adp_reg;

endmodule

/* sv/tat_checker.sv */
// ----------------------------------------------------------------------------
// tat_checker
// Port level checks of the flow tracker's result words, bound to the top.
// ----------------------------------------------------------------------------
module tat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        flow_hit,
    input logic [5:0]  flow_slot,
    input logic [2:0]  event_res,
    input logic        dup_ack_request,
    input logic [6:0]  dup_ack_count,
    input logic [31:0] dup_adapter
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(flow_hit) &&
        $stable(flow_slot) && $stable(event_res) && $stable(dup_ack_request) &&
        $stable(dup_ack_count) && $stable(dup_adapter))
        else $error("result word changed while stalled");

    // no flow: slot is zero and only none or table_full can be reported
    a_miss_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !flow_hit |-> flow_slot == 6'd0 &&
        (event_res == tat_pkg::EV_NONE || event_res == tat_pkg::EV_FULL))
        else $error("miss word carries flow data");

    // a table_full word carries no flow and no duplicate ack request
    a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tat_pkg::EV_FULL |-> !flow_hit && !dup_ack_request)
        else $error("table_full word with a flow");

    // duplicate ack request needs a flow and a count of at least three
    a_dup_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dup_ack_request |-> flow_hit && dup_ack_count >= tat_pkg::BASE_DUPS)
        else $error("bad duplicate ack request");

    // no request: count and adapter read zero
    a_nodup_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dup_ack_request |-> dup_ack_count == 7'd0 && dup_adapter == 32'd0)
        else $error("duplicate ack fields set without request");

endmodule

bind tcp_ack_timeout_flow_tracker tat_checker u_tat_checker (.*);

/* tb/sv/tb_tcp_ack_timeout_flow_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_ack_timeout_flow_tracker
// Self-checking bench for the tcp ack timeout flow tracker. A local model of
// the flow table predicts every result word, which is checked field by field.
// Directed packets cover the flow lifecycle, refresh and full buckets. Random
// traffic then runs tcp sessions over a small pool of colliding flows under
// several register settings, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_tcp_ack_timeout_flow_tracker;

    localparam int          ENTRIES     = tat_pkg::DEF_BUCKETS * tat_pkg::DEF_WAYS;
    localparam int          POOL_SIZE   = 24;
    localparam int          IDLE_PCT    = 12;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [7:0]  FL_PSH      = 8'h08;

    // one packet header
    typedef struct packed {
        logic        outbound;
        logic        tcp_valid;
        logic [7:0]  tcp_flags;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [15:0] local_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [31:0] now_ticks;
        logic [31:0] adapter_id;
    } packet_t;

    // one result word
    typedef struct packed {
        logic            flow_hit;
        logic [5:0]      flow_slot;
        tat_pkg::event_t event_res;
        logic            dup_ack_request;
        logic [6:0]      dup_ack_count;
        logic [31:0]     dup_adapter;
    } verdict_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tat_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_ready;
    logic                        outbound;
    logic                        tcp_valid;
    logic [7:0]                  tcp_flags;
    logic [31:0]                 peer_ip;
    logic [15:0]                 peer_port;
    logic [15:0]                 local_port;
    logic [31:0]                 seq_num;
    logic [31:0]                 ack_num;
    logic [31:0]                 now_ticks;
    logic [31:0]                 adapter_id;
    logic                        out_valid;
    logic                        out_ready;
    logic                        flow_hit;
    logic [5:0]                  flow_slot;
    logic [2:0]                  event_res;
    logic                        dup_ack_request;
    logic [6:0]                  dup_ack_count;
    logic [31:0]                 dup_adapter;

    // local copy of the flow table and registers
    bit                  flow_valid    [ENTRIES];
    logic [63:0]         flow_key      [ENTRIES];
    bit                  flow_est      [ENTRIES];
    logic [31:0]         flow_adapter  [ENTRIES];
    logic [31:0]         flow_sent_seq [ENTRIES];
    logic [31:0]         flow_rcv_ack  [ENTRIES];
    logic [31:0]         flow_rcv_time [ENTRIES];
    bit                  flow_rcv_seen [ENTRIES];
    logic [31:0]         cfg_timeout;
    logic [5:0]          cfg_dup_extra;

    verdict_t            expected_verdicts[$];
    verdict_t            want;
    int                  mismatches;
    int                  tcp_items;
    int                  hold_requests;
    bit                  idle_on;
    logic [31:0]         tick_now;

    // flow pool for random sessions, several flows per bucket
    logic [31:0]         pool_ip    [POOL_SIZE];
    logic [15:0]         pool_pport [POOL_SIZE];
    logic [15:0]         pool_lport [POOL_SIZE];

    tcp_ack_timeout_flow_tracker uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .outbound        (outbound),
        .tcp_valid       (tcp_valid),
        .tcp_flags       (tcp_flags),
        .peer_ip         (peer_ip),
        .peer_port       (peer_port),
        .local_port      (local_port),
        .seq_num         (seq_num),
        .ack_num         (ack_num),
        .now_ticks       (now_ticks),
        .adapter_id      (adapter_id),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .flow_hit        (flow_hit),
        .flow_slot       (flow_slot),
        .event_res       (event_res),
        .dup_ack_request (dup_ack_request),
        .dup_ack_count   (dup_ack_count),
        .dup_adapter     (dup_adapter)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // flow table model
    // ------------------------------------------------------------------------

    function automatic void clear_flow(input int s);
        flow_est[s]      = 1'b0;
        flow_adapter[s]  = '0;
        flow_rcv_time[s] = '0;
        flow_rcv_seen[s] = 1'b0;
    endfunction

    function automatic verdict_t track_packet(input packet_t p);
        verdict_t    v;
        logic [63:0] key;
        logic [31:0] gap;
        logic [31:0] next_seq;
        int          base;
        int          slot;
        bit          hit;
        bit          done;
        v           = '0;
        v.event_res = tat_pkg::EV_NONE;
        hit         = 1'b0;
        done        = 1'b0;
        slot        = 0;
        key         = {p.peer_ip, p.peer_port, p.local_port};
        base        = int'(p.peer_ip % tat_pkg::DEF_BUCKETS) * tat_pkg::DEF_WAYS;
        if (p.tcp_valid)
        begin
            // lookup in the bucket
            for (int w = 0; w < tat_pkg::DEF_WAYS; w++)
            begin
                if (!hit && flow_valid[base + w] && flow_key[base + w] == key)
                begin
                    hit  = 1'b1;
                    slot = base + w;
                end
            end
            // syn+ack creates or refreshes
            if (p.tcp_flags == tat_pkg::FL_SYNACK)
            begin
                if (hit)
                begin
                    clear_flow(slot);
                    v.event_res = tat_pkg::EV_CREATED;
                end
                else
                begin
                    for (int w = 0; w < tat_pkg::DEF_WAYS; w++)
                    begin
                        if (!hit && !flow_valid[base + w])
                        begin
                            hit  = 1'b1;
                            slot = base + w;
                        end
                    end
                    if (hit)
                    begin
                        flow_valid[slot]    = 1'b1;
                        flow_key[slot]      = key;
                        clear_flow(slot);
                        flow_sent_seq[slot] = '0;
                        flow_rcv_ack[slot]  = '0;
                        v.event_res         = tat_pkg::EV_CREATED;
                    end
                    else
                        v.event_res = tat_pkg::EV_FULL;
                end
            end
            if (hit)
            begin
                // outbound side, first pure ack establishes
                if (p.outbound)
                begin
                    flow_sent_seq[slot] = p.seq_num;
                    if ((p.tcp_flags & tat_pkg::FL_ACK) != 0 &&
                        (p.tcp_flags & tat_pkg::FL_SYN) == 0 &&
                        !flow_rcv_seen[slot] && !flow_est[slot])
                    begin
                        flow_est[slot]     = 1'b1;
                        flow_adapter[slot] = p.adapter_id;
                        v.event_res        = tat_pkg::EV_ESTAB;
                        done               = 1'b1;
                    end
                end
                if (!done)
                begin
                    // inbound ack silence check
                    if (!p.outbound && (p.tcp_flags & (tat_pkg::FL_ACK | tat_pkg::FL_SYN))
                        == tat_pkg::FL_ACK)
                    begin
                        gap      = p.now_ticks - flow_rcv_time[slot];
                        next_seq = flow_sent_seq[slot] + 32'd1;
                        if (flow_rcv_seen[slot] && gap > cfg_timeout &&
                            next_seq > flow_rcv_ack[slot])
                        begin
                            v.dup_ack_request = 1'b1;
                            v.dup_ack_count   = tat_pkg::BASE_DUPS + 7'(cfg_dup_extra);
                            v.dup_adapter     = flow_adapter[slot];
                        end
                        flow_rcv_ack[slot]  = p.ack_num;
                        flow_rcv_time[slot] = p.now_ticks;
                        flow_rcv_seen[slot] = 1'b1;
                    end
                    // fin or rst removes
                    if ((p.tcp_flags & (tat_pkg::FL_FIN | tat_pkg::FL_RST)) != 0)
                    begin
                        flow_valid[slot] = 1'b0;
                        v.event_res      = tat_pkg::EV_FINISHED;
                    end
                end
            end
        end
        v.flow_hit  = hit;
        v.flow_slot = hit ? 6'(slot) : 6'd0;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result word with no packet waiting for it");
                mismatches++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                compare_field("flow_hit", 32'(want.flow_hit), 32'(flow_hit));
                compare_field("flow_slot", 32'(want.flow_slot), 32'(flow_slot));
                compare_field("event_res", 32'(want.event_res), 32'(event_res));
                compare_field("dup_ack_request", 32'(want.dup_ack_request),
                              32'(dup_ack_request));
                compare_field("dup_ack_count", 32'(want.dup_ack_count), 32'(dup_ack_count));
                compare_field("dup_adapter", want.dup_adapter, dup_adapter);
            end
        end
    end

    // result receiver: random stalls plus long hold on request
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = tat_pkg::PADDR_W'({sel, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (sel == tat_pkg::REG_TIMEOUT)
            cfg_timeout = value;
        else
            cfg_dup_extra = value[5:0];
    endtask

    // wait for all expected result words to drain, then program both registers
    task automatic set_config(input logic [31:0] timeout_val, input logic [5:0] dup_val);
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
        write_reg(tat_pkg::REG_TIMEOUT, timeout_val);
        write_reg(tat_pkg::REG_DUP_EXTRA, 32'(dup_val));
    endtask

    // send one word, record its prediction once accepted
    task automatic send_packet(input packet_t p);
        if (idle_on && $urandom_range(99) < IDLE_PCT)
            repeat ($urandom_range(1, 3))
                @(negedge clk);
        outbound   = p.outbound;
        tcp_valid  = p.tcp_valid;
        tcp_flags  = p.tcp_flags;
        peer_ip    = p.peer_ip;
        peer_port  = p.peer_port;
        local_port = p.local_port;
        seq_num    = p.seq_num;
        ack_num    = p.ack_num;
        now_ticks  = p.now_ticks;
        adapter_id = p.adapter_id;
        in_valid   = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        expected_verdicts.insert(expected_verdicts.size(), track_packet(p));
        if (p.tcp_valid)
            tcp_items++;
    endtask

    function automatic packet_t make_packet(input logic outb, input logic [7:0] flags,
                                            input logic [31:0] ip, input logic [15:0] pport,
                                            input logic [15:0] lport, input logic [31:0] seq,
                                            input logic [31:0] ack, input logic [31:0] now,
                                            input logic [31:0] adapter);
        packet_t p;
        p.outbound   = outb;
        p.tcp_valid  = 1'b1;
        p.tcp_flags  = flags;
        p.peer_ip    = ip;
        p.peer_port  = pport;
        p.local_port = lport;
        p.seq_num    = seq;
        p.ack_num    = ack;
        p.now_ticks  = now;
        p.adapter_id = adapter;
        return p;
    endfunction

    // packet on a pool flow at the current tick
    task automatic send_flow(input int idx, input logic outb, input logic [7:0] flags,
                             input logic [31:0] seq, input logic [31:0] ack);
        send_packet(make_packet(outb, flags, pool_ip[idx], pool_pport[idx], pool_lport[idx],
                                seq, ack, tick_now, $urandom));
    endtask

    // one tcp session: handshake, data and acks, usually a close
    task automatic flow_session(input int idx);
        logic [31:0] seq_cur;
        int          r;
        if ($urandom_range(3) == 0)
            seq_cur = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            seq_cur = $urandom;
        send_flow(idx, $urandom_range(7) == 0, tat_pkg::FL_SYNACK, $urandom, $urandom);
        if ($urandom_range(9) != 0)
            send_flow(idx, 1'b1,
                      $urandom_range(1) ? tat_pkg::FL_ACK : (tat_pkg::FL_ACK | FL_PSH),
                      seq_cur, $urandom);
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(2) == 0)
            begin
                seq_cur += $urandom_range(1, 1500);
                send_flow(idx, 1'b1, tat_pkg::FL_ACK, seq_cur, $urandom);
            end
            else
            begin
                // silence around the timeout boundary
                case ($urandom_range(3))
                    0:       tick_now += cfg_timeout;
                    1:       tick_now += cfg_timeout + 32'd1;
                    2:       tick_now += $urandom_range(0, 50);
                    default: tick_now += $urandom;
                endcase
                send_flow(idx, 1'b0, tat_pkg::FL_ACK, $urandom,
                          $urandom_range(1) ? seq_cur + 32'd1 : seq_cur - $urandom_range(0, 3000));
            end
        end
        r = $urandom_range(99);
        if (r < 40)
            send_flow(idx, 1'($urandom_range(1)), tat_pkg::FL_FIN | tat_pkg::FL_ACK, seq_cur,
                      seq_cur + 32'd1);
        else if (r < 55)
            send_flow(idx, 1'($urandom_range(1)), tat_pkg::FL_RST, seq_cur, '0);
    endtask

    // mostly sessions, the rest random headers
    task automatic random_traffic(input int n);
        packet_t p;
        int      goal;
        goal = tcp_items + n;
        while (tcp_items < goal)
        begin
            if ($urandom_range(99) < 75)
                flow_session($urandom_range(POOL_SIZE - 1));
            else
            begin
                p = make_packet(1'($urandom), 8'($urandom), $urandom, 16'($urandom),
                                16'($urandom), $urandom, $urandom, $urandom, $urandom);
                p.tcp_valid = ($urandom_range(9) != 0);
                case ($urandom_range(5))
                    1:       p.tcp_flags = tat_pkg::FL_SYNACK;
                    2:       p.tcp_flags = tat_pkg::FL_ACK;
                    3:       p.tcp_flags = tat_pkg::FL_FIN | tat_pkg::FL_ACK;
                    4:       p.tcp_flags = tat_pkg::FL_RST;
                    5:       p.tcp_flags = tat_pkg::FL_SYN;
                    default: p.tcp_flags = 8'($urandom);
                endcase
                if ($urandom_range(1))
                begin
                    r_pool: begin
                        int idx;
                        idx          = $urandom_range(POOL_SIZE - 1);
                        p.peer_ip    = pool_ip[idx];
                        p.peer_port  = pool_pport[idx];
                        p.local_port = pool_lport[idx];
                    end
                end
                send_packet(p);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // create, establish, timeouts and close on one flow
    task automatic test_lifecycle();
        packet_t p;
        set_config(32'd20, 6'd63);
        // non tcp word is ignored
        p = make_packet(1'b1, '1, '1, '1, '1, '1, '1, '1, '1);
        p.tcp_valid = 1'b0;
        send_packet(p);
        send_packet(make_packet(1'b0, tat_pkg::FL_SYNACK, '0, '0, '0, '0, '0, 32'd0, '0));
        // adapter zero is a real adapter
        send_packet(make_packet(1'b1, tat_pkg::FL_ACK, '0, '0, '0, '1, '0, 32'd0, 32'd0));
        // establishes only once
        send_packet(make_packet(1'b1, tat_pkg::FL_ACK, '0, '0, '0, '1, '0, 32'd0, 32'd5));
        send_packet(make_packet(1'b0, tat_pkg::FL_ACK, '0, '0, '0, '0, 32'd5, 32'd10, '0));
        // sent seq + 1 wraps to zero, no request
        send_packet(make_packet(1'b0, tat_pkg::FL_ACK, '0, '0, '0, '0, 32'd100, 32'd100, '0));
        send_packet(make_packet(1'b1, tat_pkg::FL_ACK, '0, '0, '0, 32'd1000, '0, 32'd100, '0));
        send_packet(make_packet(1'b0, tat_pkg::FL_ACK, '0, '0, '0, '0, 32'd7, 32'd121, '0));
        // gap equal to timeout
        send_packet(make_packet(1'b0, tat_pkg::FL_ACK, '0, '0, '0, '0, 32'd8, 32'd141, '0));
        // fin together with a timeout
        send_packet(make_packet(1'b0, tat_pkg::FL_FIN | tat_pkg::FL_ACK, '0, '0, '0, '0,
                                32'd9, 32'd500, '0));
    endtask

    // refresh of a known flow, then a full bucket
    task automatic test_refresh_and_full();
        send_packet(make_packet(1'b0, tat_pkg::FL_SYNACK, '1, '1, '1, '0, '0, '0, '0));
        send_packet(make_packet(1'b1, tat_pkg::FL_ACK, '1, '1, '1, 32'd50, '0, '0, '1));
        send_packet(make_packet(1'b0, tat_pkg::FL_ACK, '1, '1, '1, '0, 32'd0, 32'd0, '0));
        send_packet(make_packet(1'b0, tat_pkg::FL_ACK, '1, '1, '1, '0, 32'd1, '1, '0));
        send_packet(make_packet(1'b1, tat_pkg::FL_SYNACK, '1, '1, '1, 32'd77, '0, '0, '0));
        send_packet(make_packet(1'b1, tat_pkg::FL_ACK | FL_PSH, '1, '1, '1, 32'd80, '0, '0,
                                32'd1234));
        send_packet(make_packet(1'b0, tat_pkg::FL_RST | tat_pkg::FL_ACK, '1, '1, '1, '0,
                                32'd2, '0, '0));
        // five flows into one bucket of four ways
        for (int i = 0; i < tat_pkg::DEF_WAYS + 1; i++)
            send_packet(make_packet(1'b0, tat_pkg::FL_SYNACK, 32'h0000_0005 + 32'(i << 8),
                                    16'(i), 16'(i), '0, '0, '0, '0));
        for (int i = 0; i < tat_pkg::DEF_WAYS; i++)
            send_packet(make_packet(1'b0, tat_pkg::FL_RST, 32'h0000_0005 + 32'(i << 8),
                                    16'(i), 16'(i), '0, '0, '0, '0));
    endtask

    // random sessions under several register settings
    task automatic test_random_traffic();
        set_config(32'd0, 6'd0);
        random_traffic(250);
        set_config('1, 6'd61);
        random_traffic(250);
        // stretch with no idling on either side
        idle_on = 1'b0;
        set_config(32'd40, 6'($urandom_range(63)));
        random_traffic(250);
        idle_on = 1'b1;
        set_config($urandom_range(1, 5000), 6'($urandom_range(63)));
        random_traffic(250);
        set_config(32'd1, 6'd63);
        random_traffic(200);
    endtask

    // receiver holds off while packets keep coming
    task automatic test_backpressure();
        set_config(32'd100, 6'd2);
        hold_requests++;
        random_traffic(60);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        outbound      = 1'b0;
        tcp_valid     = 1'b0;
        tcp_flags     = '0;
        peer_ip       = '0;
        peer_port     = '0;
        local_port    = '0;
        seq_num       = '0;
        ack_num       = '0;
        now_ticks     = '0;
        adapter_id    = '0;
        mismatches    = 0;
        tcp_items     = 0;
        hold_requests = 0;
        idle_on       = 1'b1;
        tick_now      = $urandom;
        cfg_timeout   = '0;
        cfg_dup_extra = '0;
        foreach (flow_valid[i])
            flow_valid[i] = 1'b0;
        // pool flows over four buckets, later half reuses addresses
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i < POOL_SIZE / 2)
                pool_ip[i] = {28'($urandom >> 4), 4'((i % 4) * 5)};
            else
                pool_ip[i] = pool_ip[i - POOL_SIZE / 2];
            pool_pport[i] = 16'($urandom);
            pool_lport[i] = 16'($urandom);
        end
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        test_lifecycle();
        test_refresh_and_full();
        test_random_traffic();
        test_backpressure();

        // drain and settle
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
sv/tat_pkg.sv
sv/tat_ram.sv
sv/tcp_ack_timeout_flow_tracker.sv
sv/tat_checker.sv
tb/sv/tb_tcp_ack_timeout_flow_tracker.sv
